FILE: rtl/core/tfc_pkg.sv
// Shared types and constants for the TLV field framer with CRC-16.
package tfc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_ID     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_ENABLE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_ENABLE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_OFFSET = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Output slots of one input item, in emission order.
    localparam int NUM_SLOTS   = 5;
    localparam int SLOT_ID     = 0;
    localparam int SLOT_LEN    = 1;
    localparam int SLOT_DATA   = 2;
    localparam int SLOT_CRC_LO = 3;
    localparam int SLOT_CRC_HI = 4;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        logic [7:0] field_id;
        logic [7:0] field_length;
        logic       head_enable;
        logic       crc_enable;
        logic [8:0] field_offset;
    } cfg_t;

    // Everything the emitter needs to serialize the results of one input item.
    typedef struct packed {
        slot_mask_t  slots;
        logic [7:0]  field_id;
        logic [7:0]  field_length;
        logic [7:0]  data_byte;
        logic [15:0] crc;
        logic [8:0]  base;
        logic [8:0]  data_rel;
        logic        data_done;
    } job_t;

endpackage

FILE: rtl/core/tlv_field_framer_crc16.sv
// The field engine updates the byte position and the CRC-16/CCITT-FALSE of each
// input byte in one combinational byte step and hands a job to the emitter, which
// holds one job and sends its frame bytes through one output register at one byte
// per cycle while the output is not stalled. An input transfer produces one frame
// byte for a plain payload byte, three for the first byte of a field with the head
// enabled, three for the last byte with CRC enabled, and up to five for a one-byte
// field with both; a new byte is taken in the cycle the previous job's final byte
// moves to the output register. There is no clearing pass after reset.
module tlv_field_framer_crc16
    import tfc_pkg::*;
#(
    parameter int FRAME_BYTES = 512
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] payload_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [7:0] out_byte, [16:8] out_address, zeros
    output logic                   m_tlast,   // run_last
    output logic                   m_tuser    // field_done
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    job_t       job;
    logic       accept;
    logic [7:0] out_byte;
    logic [8:0] out_address;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FIELD_ID:     cfg_next.field_id     = cfg_wdata[7:0];
                REG_FIELD_LENGTH: cfg_next.field_length = cfg_wdata[7:0];
                REG_HEAD_ENABLE:  cfg_next.head_enable  = cfg_wdata[0];
                REG_CRC_ENABLE:   cfg_next.crc_enable   = cfg_wdata[0];
                REG_FIELD_OFFSET: cfg_next.field_offset = cfg_wdata[8:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.field_id     <= 8'd0;
            cfg_reg.field_length <= 8'd1;
            cfg_reg.head_enable  <= 1'b1;
            cfg_reg.crc_enable   <= 1'b1;
            cfg_reg.field_offset <= 9'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    tfc_field_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_tdata),
        .accept  (accept),
        .job     (job)
    );

    tfc_emitter #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_in       (job),
        .job_accept   (accept),
        .job_ready    (s_tready),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_byte       (out_byte),
        .m_address    (out_address),
        .m_run_last   (m_tlast),
        .m_field_done (m_tuser)
    );

    assign m_tdata = {7'd0, out_address, out_byte};

endmodule

FILE: rtl/core/tfc_field_engine.sv
// Field state (byte position and running CRC) and the per-item job builder.
module tfc_field_engine
    import tfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic [7:0] s_data,
    input  logic       accept,
    output job_t       job
);

    logic [7:0]  byte_position_reg;
    logic [7:0]  byte_position_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    logic [7:0]  position_inc;
    logic        head;
    logic        last;
    logic [15:0] crc_new;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    always_comb begin
        head         = (byte_position_reg == 8'd0) && cfg.head_enable;
        position_inc = byte_position_reg + 8'd1;
        last         = (position_inc == cfg.field_length);
        crc_new      = crc_byte(crc_reg, s_data);

        job.slots                = '0;
        job.slots[SLOT_ID]       = head;
        job.slots[SLOT_LEN]      = head;
        job.slots[SLOT_DATA]     = 1'b1;
        job.slots[SLOT_CRC_LO]   = last && cfg.crc_enable;
        job.slots[SLOT_CRC_HI]   = last && cfg.crc_enable;
        job.field_id             = cfg.field_id;
        job.field_length         = cfg.field_length;
        job.data_byte            = s_data;
        job.crc                  = crc_new;
        job.base                 = cfg.field_offset;
        // The payload sits behind the two head bytes whenever the head is enabled.
        job.data_rel             = {1'b0, byte_position_reg}
                                   + (cfg.head_enable ? 9'd2 : 9'd0);
        job.data_done            = last && !cfg.crc_enable;

        byte_position_next = byte_position_reg;
        crc_next           = crc_reg;
        if (accept) begin
            if (last) begin
                byte_position_next = 8'd0;
                crc_next           = CRC_INIT;
            end else begin
                byte_position_next = position_inc;
                crc_next           = crc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= 8'd0;
            crc_reg           <= CRC_INIT;
        end else begin
            byte_position_reg <= byte_position_next;
            crc_reg           <= crc_next;
        end
    end

endmodule

FILE: rtl/core/tfc_emitter.sv
// Job holding register and output register that serialize one job into frame bytes.
module tfc_emitter
    import tfc_pkg::*;
#(
    parameter int FRAME_BYTES = 512
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        job_in,
    input  logic        job_accept,
    output logic        job_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte,
    output logic [8:0]  m_address,
    output logic        m_run_last,
    output logic        m_field_done
);

    localparam int SUM_W = 10;
    localparam int RED_W = $clog2(FRAME_BYTES) + 5;
    // Offset plus position stays below 16 frames for the smallest frame size.
    localparam int RED_STEPS = 4;

    job_t       job_reg;
    job_t       job_next;
    logic       job_valid_reg;
    logic       job_valid_next;
    slot_mask_t slots_reg;
    slot_mask_t slots_next;

    logic       m_valid_reg;
    logic       m_valid_next;
    logic [7:0] m_byte_reg;
    logic [7:0] m_byte_next;
    logic [8:0] m_address_reg;
    logic [8:0] m_address_next;
    logic       m_run_last_reg;
    logic       m_run_last_next;
    logic       m_field_done_reg;
    logic       m_field_done_next;

    slot_mask_t remaining;
    slot_mask_t pick;
    slot_mask_t remaining_after;
    logic       out_free;
    logic       load;
    logic       job_last;
    logic [7:0] sel_byte;
    logic [8:0] sel_rel;
    logic       sel_done;
    logic [SUM_W-1:0] addr_sum;

    function automatic logic [8:0] frame_mod(input logic [SUM_W-1:0] x_in);
        logic [RED_W-1:0] x;
        logic [RED_W-1:0] m;
        x = RED_W'(x_in);
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            m = RED_W'(FRAME_BYTES) << k;
            if (x >= m) begin
                x = x - m;
            end
        end
        return x[8:0];
    endfunction

    always_comb begin
        remaining = job_valid_reg ? slots_reg : '0;
        out_free  = !m_valid_reg || m_ready;
        load      = out_free && job_valid_reg;

        pick     = '0;
        sel_byte = 8'd0;
        sel_rel  = 9'd0;
        sel_done = 1'b0;
        priority if (remaining[SLOT_ID]) begin
            pick[SLOT_ID] = 1'b1;
            sel_byte      = job_reg.field_id;
            sel_rel       = 9'd0;
        end else if (remaining[SLOT_LEN]) begin
            pick[SLOT_LEN] = 1'b1;
            sel_byte       = job_reg.field_length;
            sel_rel        = 9'd1;
        end else if (remaining[SLOT_DATA]) begin
            pick[SLOT_DATA] = 1'b1;
            sel_byte        = job_reg.data_byte;
            sel_rel         = job_reg.data_rel;
            sel_done        = job_reg.data_done;
        end else if (remaining[SLOT_CRC_LO]) begin
            pick[SLOT_CRC_LO] = 1'b1;
            sel_byte          = job_reg.crc[7:0];
            sel_rel           = job_reg.data_rel + 9'd1;
        end else begin
            pick[SLOT_CRC_HI] = 1'b1;
            sel_byte          = job_reg.crc[15:8];
            sel_rel           = job_reg.data_rel + 9'd2;
            sel_done          = 1'b1;
        end

        remaining_after = remaining & ~pick;
        job_last        = (remaining_after == '0);
        // The slot frees up in the same cycle that its final byte moves out.
        job_ready       = !job_valid_reg || (load && job_last);

        addr_sum = {1'b0, job_reg.base} + {1'b0, sel_rel};

        m_valid_next      = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_byte_next       = m_byte_reg;
        m_address_next    = m_address_reg;
        m_run_last_next   = m_run_last_reg;
        m_field_done_next = m_field_done_reg;
        if (load) begin
            m_byte_next       = sel_byte;
            m_address_next    = frame_mod(addr_sum);
            m_run_last_next   = job_last;
            m_field_done_next = sel_done;
        end

        job_next       = job_reg;
        slots_next     = slots_reg;
        job_valid_next = job_valid_reg;
        if (job_accept) begin
            job_next       = job_in;
            slots_next     = job_in.slots;
            job_valid_next = 1'b1;
        end else if (load) begin
            slots_next     = remaining_after;
            job_valid_next = !job_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg          <= job_next;
        slots_reg        <= slots_next;
        m_byte_reg       <= m_byte_next;
        m_address_reg    <= m_address_next;
        m_run_last_reg   <= m_run_last_next;
        m_field_done_reg <= m_field_done_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_byte       = m_byte_reg;
    assign m_address    = m_address_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_field_done = m_field_done_reg;

endmodule

FILE: rtl/core/tfc_checker.sv
// Port-level checks for the TLV field framer and their attachment to the top level.
module tfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // The final byte of a field always closes the run of its input transfer.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("field_done without run_last");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:17] == 7'd0))
        else $error("tdata padding bits not zero");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("stalled output transfer changed");

    // Every input transfer is followed by a valid frame byte on the output.
    a_input_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("input transfer produced no output");

endmodule

bind tlv_field_framer_crc16 tfc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: test/tb_tlv_field_framer_crc16.sv
// Self-checking testbench for the TLV field framer: predicts every frame byte and address.
`timescale 1ns / 1ps

module tb_tlv_field_framer_crc16;
    import tfc_pkg::*;

    localparam int FRAME_BYTES = 512;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_REG = 3'd7;

    typedef struct packed {
        logic [7:0] byte_val;
        logic [8:0] addr;
        logic       run_last;
        logic       field_done;
    } frame_byte_t;

    // Tracks the field in progress and holds the frame bytes still owed by the block.
    class tlv_frame_tracker;
        cfg_t        regs;
        logic [7:0]  position;
        logic [15:0] crc;
        frame_byte_t pending[$];
        int          errors;

        function new();
            regs.field_id     = 8'd0;
            regs.field_length = 8'd1;
            regs.head_enable  = 1'b1;
            regs.crc_enable   = 1'b1;
            regs.field_offset = 9'd0;
            position = 8'd0;
            crc      = CRC_INIT;
            errors   = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FIELD_ID:     regs.field_id     = val[7:0];
                REG_FIELD_LENGTH: regs.field_length = val[7:0];
                REG_HEAD_ENABLE:  regs.head_enable  = val[0];
                REG_CRC_ENABLE:   regs.crc_enable   = val[0];
                REG_FIELD_OFFSET: regs.field_offset = val[8:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            c ^= {b, 8'h00};
            for (int k = 0; k < 8; k++)
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void owe(logic [7:0] b, int rel, logic done);
            frame_byte_t fb;
            fb.byte_val   = b;
            fb.addr       = 9'((int'(regs.field_offset) + rel) % FRAME_BYTES);
            fb.run_last   = 1'b0;
            fb.field_done = done;
            pending.push_back(fb);
        endfunction

        function void take_payload(logic [7:0] b);
            int          hdr;
            logic [7:0]  next;
            logic        last;
            frame_byte_t tail;
            hdr = regs.head_enable ? 2 : 0;
            if (position == 8'd0 && regs.head_enable) begin
                owe(regs.field_id, 0, 1'b0);
                owe(regs.field_length, 1, 1'b0);
            end
            next = position + 8'd1;
            last = (next == regs.field_length);
            owe(b, hdr + position, last && !regs.crc_enable);
            crc = crc_byte(crc, b);
            if (last) begin
                if (regs.crc_enable) begin
                    owe(crc[7:0], hdr + position + 1, 1'b0);
                    owe(crc[15:8], hdr + position + 2, 1'b1);
                end
                position = 8'd0;
                crc      = CRC_INIT;
            end else begin
                position = next;
            end
            // The final byte caused by this payload byte closes the run.
            tail = pending.pop_back();
            tail.run_last = 1'b1;
            pending.push_back(tail);
        endfunction

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_frame_byte(logic [23:0] tdata, logic tlast, logic tuser);
            frame_byte_t want;
            if (pending.size() == 0) begin
                report($sformatf("frame byte 0x%0h with nothing expected", tdata));
                return;
            end
            want = pending.pop_front();
            check_field("out_byte", 16'(tdata[7:0]), 16'(want.byte_val));
            check_field("out_address", 16'(tdata[16:8]), 16'(want.addr));
            check_field("tdata padding", 16'(tdata[23:17]), 16'd0);
            check_field("run_last", 16'(tlast), 16'(want.run_last));
            check_field("field_done", 16'(tuser), 16'(want.field_done));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    tlv_frame_tracker trk = new();
    bit steady_flow = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;

    tlv_field_framer_crc16 #(.FRAME_BYTES(FRAME_BYTES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL tlv_field_framer_crc16");
            $finish;
        end
    end

    // Result side: check each transfer, then stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            trk.check_frame_byte(m_tdata, m_tlast, m_tuser);
        if (!steady_flow && stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic feed_payload(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        trk.take_payload(b);
        if (!steady_flow && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic await_frame_bytes();
        s_tvalid <= 1'b0;
        while (trk.pending.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Writes every register, plus one write to an unmapped index that must be ignored.
    task automatic set_field(input logic [8:0] id, len, head, crc, offset);
        logic [CFG_INDEX_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0]  val [6];
        idx = '{UNUSED_REG, REG_FIELD_ID, REG_FIELD_LENGTH, REG_HEAD_ENABLE,
                REG_CRC_ENABLE, REG_FIELD_OFFSET};
        val = '{9'($urandom), id, len, head, crc, offset};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            trk.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Sends at least min_items bytes and then finishes the field in progress.
    task automatic run_fields(input int min_items);
        for (int i = 0; i < min_items; i++)
            feed_payload(8'($urandom));
        while (trk.position != 8'd0)
            feed_payload(8'($urandom));
    endtask

    initial begin
        logic [8:0] len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one-byte fields with head and CRC, five bytes per transfer.
        feed_payload(8'h00);
        feed_payload(8'hFF);

        // Field starting at the top address wraps to zero.
        await_frame_bytes();
        set_field(9'h0FF, 9'd3, 9'd1, 9'd1, 9'd511);
        feed_payload(8'h80);
        feed_payload(8'h01);
        feed_payload(8'h7F);

        // Bare payload: field_done on the last data byte; the id write is masked.
        await_frame_bytes();
        set_field(9'h1A5, 9'd2, 9'd0, 9'd0, 9'd510);
        feed_payload(8'h55);
        feed_payload(8'hAA);

        await_frame_bytes();
        set_field(9'h03C, 9'd2, 9'd0, 9'd1, 9'd0);
        feed_payload(8'h12);
        feed_payload(8'h34);

        await_frame_bytes();
        set_field(9'h042, 9'd2, 9'd1, 9'd0, 9'd7);
        feed_payload(8'h56);
        feed_payload(8'h78);

        // Settings change in the middle of a field.
        await_frame_bytes();
        set_field(9'h0C3, 9'd4, 9'd1, 9'd1, 9'd300);
        feed_payload(8'hC0);
        feed_payload(8'h3F);
        await_frame_bytes();
        set_field(9'h0C4, 9'd3, 9'd0, 9'd1, 9'd40);
        feed_payload(8'hE7);

        // Out-of-range write data is cut to each register's width.
        await_frame_bytes();
        set_field(9'h1FF, 9'h101, 9'h1FF, 9'h0FE, 9'd256);
        feed_payload(8'h18);

        // A length of zero does not close the field early, and the head sends 0 as length.
        await_frame_bytes();
        set_field(9'($urandom_range(0, 255)), 9'd0, 9'd1, 9'd1, 9'($urandom_range(0, 511)));
        repeat (4) feed_payload(8'($urandom));
        // Setting a length mid-field closes the field once the count reaches it.
        await_frame_bytes();
        set_field(9'h011, 9'd6, 9'd1, 9'd1, 9'd100);
        run_fields(0);

        for (int p = 0; p < 5; p++) begin
            await_frame_bytes();
            if ($urandom_range(0, 3) == 0)
                len = 9'($urandom_range(7, 20));
            else
                len = 9'($urandom_range(1, 6));
            set_field(9'($urandom_range(0, 255)), len, 9'($urandom_range(0, 1)),
                      9'($urandom_range(0, 1)),
                      (p == 1) ? 9'd0 : 9'($urandom_range(0, 511)));
            run_fields($urandom_range(6, 12));
        end

        // Last part runs at full rate on both sides.
        await_frame_bytes();
        steady_flow = 1'b1;
        set_field(9'($urandom_range(0, 255)), 9'd3, 9'd1, 9'd1, 9'd509);
        run_fields(20);

        await_frame_bytes();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (trk.errors == 0)
            $display("PASS tlv_field_framer_crc16");
        else
            $display("FAIL tlv_field_framer_crc16");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tfc_pkg.sv
rtl/core/tfc_field_engine.sv
rtl/core/tfc_emitter.sv
rtl/core/tlv_field_framer_crc16.sv
rtl/core/tfc_checker.sv
test/tb_tlv_field_framer_crc16.sv
